>>> hw/rtl/ecf_pkg.sv
`timescale 1ns / 1ps

package ecf_pkg;

	// field widths
	localparam int unsigned MS_W    = 32;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned FREQ_W  = 10;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned MODE_W  = 2;

	// stream widths, padded to whole bytes
	localparam int unsigned IN_TDATA_W  = 64;
	localparam int unsigned OUT_TDATA_W = 80;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 2;

	// timing constants
	localparam logic [MS_W-1:0]   ELAPSED_LIMIT = MS_W'(999);
	localparam logic [FREQ_W-1:0] FREQ_MAX      = FREQ_W'(1000);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_SRC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMER_SRC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_CLR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLR = 2'd3;

	// source modes (anything else holds)
	localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd1;

	// calendar clear intervals
	localparam logic [MODE_W-1:0] CLR_NONE    = 2'd0;
	localparam logic [MODE_W-1:0] CLR_HOURLY  = 2'd1;
	localparam logic [MODE_W-1:0] CLR_DAILY   = 2'd2;
	localparam logic [MODE_W-1:0] CLR_MONTHLY = 2'd3;

	// one service tick
	typedef struct packed {
		logic [MS_W-1:0]   now_ms;
		logic              count_level;
		logic              timer_level;
		logic              clear_count;
		logic              clear_timer;
		logic [DAY_W-1:0]  day;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} tick_t;

endpackage

>>> hw/rtl/event_counter_timer_freq_meter_top.sv
`timescale 1ns / 1ps

// Event counter, on-time timer and frequency meter. Each transfer on the input
// stream is one service tick carrying the millisecond time, the counted and
// timed levels, clear requests and the calendar time; each tick yields exactly
// one output transfer with the event count, the on-time seconds and the last
// frequency readout (edges per window of more than 999 ms, clamped to 1000).
// A tick passes an input register and then a result register, and one tick per
// cycle is sustained while the output is not stalled: the whole update is a
// single pass of compares and increments on the state registers. Configuration
// writes are always taken (cfg_ready is high) and must only be issued while no
// tick is in flight.
module event_counter_timer_freq_meter_top
	import ecf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream, tdata from bit 0: now_ms, count_level, timer_level,
	// clear_count, clear_timer, day, hour, minute, second, zero padding
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// output stream, tdata from bit 0: event_count, on_seconds, frequency,
	// zero padding
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	logic [MODE_W-1:0] count_mode_q, timer_mode_q, count_clr_q, timer_clr_q;

	// block state
	logic               last_level_q;
	logic [COUNT_W-1:0] event_counter_q;
	logic [MS_W-1:0]    window_start_q;
	logic [COUNT_W-1:0] window_edges_q;
	logic [FREQ_W-1:0]  frequency_q;
	logic [COUNT_W-1:0] on_time_q;
	logic [MS_W-1:0]    on_mark_q;

	// pipeline
	tick_t  tick_s1;
	logic   valid_s1;
	logic   advance;
	logic   step;
	tick_t  tick_in;

	// next state
	logic               last_level_d;
	logic [COUNT_W-1:0] event_counter_d;
	logic [MS_W-1:0]    window_start_d;
	logic [COUNT_W-1:0] window_edges_d;
	logic [FREQ_W-1:0]  frequency_d;
	logic [COUNT_W-1:0] on_time_d;
	logic [MS_W-1:0]    on_mark_d;
	logic [MS_W-1:0]    ws_tmp, mark_tmp;
	logic [COUNT_W-1:0] we_tmp;
	logic               at_hour, at_day, at_month;
	logic               clr_count_any, clr_timer_any;

	// output register
	logic                  out_valid_q;
	logic [COUNT_W-1:0]    out_event_q;
	logic [COUNT_W-1:0]    out_on_q;
	logic [FREQ_W-1:0]     out_freq_q;

	// handshakes
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign step          = valid_s1 && advance;
	assign cfg_ready     = 1'b1;

	// unpack the input transfer
	always_comb begin
		tick_in.now_ms      = s_axis_tdata[31:0];
		tick_in.count_level = s_axis_tdata[32];
		tick_in.timer_level = s_axis_tdata[33];
		tick_in.clear_count = s_axis_tdata[34];
		tick_in.clear_timer = s_axis_tdata[35];
		tick_in.day         = s_axis_tdata[40:36];
		tick_in.hour        = s_axis_tdata[45:41];
		tick_in.minute      = s_axis_tdata[51:46];
		tick_in.second      = s_axis_tdata[57:52];
	end

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_mode_q <= MODE_OFF;
			timer_mode_q <= MODE_OFF;
			count_clr_q  <= CLR_NONE;
			timer_clr_q  <= CLR_NONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COUNT_SRC: count_mode_q <= cfg_data;
				REG_TIMER_SRC: timer_mode_q <= cfg_data;
				REG_COUNT_CLR: count_clr_q  <= cfg_data;
				REG_TIMER_CLR: timer_clr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			tick_s1 <= tick_in;
		end
	end

	// single-pass update of counters, window and timer
	always_comb begin
		last_level_d    = last_level_q;
		event_counter_d = event_counter_q;
		we_tmp          = window_edges_q;
		frequency_d     = frequency_q;
		on_time_d       = on_time_q;
		on_mark_d       = on_mark_q;

		// edge counting
		if (count_mode_q == MODE_OFF) begin
			event_counter_d = '0;
		end else if (count_mode_q == MODE_ACTIVE) begin
			last_level_d = tick_s1.count_level;
			if (tick_s1.count_level && !last_level_q) begin
				event_counter_d = event_counter_q + COUNT_W'(1);
				we_tmp          = window_edges_q + COUNT_W'(1);
			end
		end

		// frequency window, restarted on clock rollover
		ws_tmp = window_start_q;
		if (tick_s1.now_ms < window_start_q) begin
			ws_tmp = tick_s1.now_ms;
			we_tmp = '0;
		end
		window_start_d = ws_tmp;
		window_edges_d = we_tmp;
		if ((tick_s1.now_ms - ws_tmp) > ELAPSED_LIMIT) begin
			window_start_d = tick_s1.now_ms;
			window_edges_d = '0;
			if (we_tmp > COUNT_W'(FREQ_MAX)) begin
				frequency_d = FREQ_MAX;
			end else begin
				frequency_d = we_tmp[FREQ_W-1:0];
			end
		end

		// on-time timer
		mark_tmp = (tick_s1.now_ms < on_mark_q) ? '0 : on_mark_q;
		if (timer_mode_q == MODE_OFF) begin
			on_time_d = '0;
		end else if (timer_mode_q == MODE_ACTIVE) begin
			if (tick_s1.timer_level) begin
				on_mark_d = mark_tmp;
				if ((tick_s1.now_ms - mark_tmp) > ELAPSED_LIMIT) begin
					on_mark_d = tick_s1.now_ms;
					on_time_d = on_time_q + COUNT_W'(1);
				end
			end else begin
				on_mark_d = tick_s1.now_ms;
			end
		end

		// manual and calendar clears
		at_hour  = (tick_s1.minute == '0) && (tick_s1.second == '0);
		at_day   = at_hour && (tick_s1.hour == '0);
		at_month = at_day && (tick_s1.day == '0);
		clr_count_any = tick_s1.clear_count
			|| (at_month && count_clr_q == CLR_MONTHLY)
			|| (at_day && count_clr_q == CLR_DAILY)
			|| (at_hour && count_clr_q == CLR_HOURLY);
		clr_timer_any = tick_s1.clear_timer
			|| (at_month && timer_clr_q == CLR_MONTHLY)
			|| (at_day && timer_clr_q == CLR_DAILY)
			|| (at_hour && timer_clr_q == CLR_HOURLY);
		if (clr_count_any) begin
			event_counter_d = '0;
		end
		if (clr_timer_any) begin
			on_time_d = '0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q    <= 1'b0;
			event_counter_q <= '0;
			window_start_q  <= '0;
			window_edges_q  <= '0;
			frequency_q     <= '0;
			on_time_q       <= '0;
			on_mark_q       <= '0;
		end else if (step) begin
			last_level_q    <= last_level_d;
			event_counter_q <= event_counter_d;
			window_start_q  <= window_start_d;
			window_edges_q  <= window_edges_d;
			frequency_q     <= frequency_d;
			on_time_q       <= on_time_d;
			on_mark_q       <= on_mark_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_event_q <= event_counter_d;
			out_on_q    <= on_time_d;
			out_freq_q  <= frequency_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_freq_q, out_on_q, out_event_q};

endmodule

>>> hw/rtl/ecf_checker.sv
`timescale 1ns / 1ps

module ecf_checker
	import ecf_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// frequency readout never exceeds the clamp
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[73:64] <= FREQ_MAX))
		else $error("frequency above clamp");

	// an empty result register never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// a result appears only for a tick taken by the input register and passed on to the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without a tick");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind event_counter_timer_freq_meter_top ecf_checker u_ecf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
